FILE: src/assert_macros.svh
// Assertion helpers used by the address filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

FILE: src/erxaf_pkg.sv
// ----------------------------------------------------------------------------
// erxaf_pkg
// Types, constants and helpers of the receive address filter.
// ----------------------------------------------------------------------------
package erxaf_pkg;

    localparam int GROUP_TABLE_DEPTH = 16;
    localparam int IDX_W = (GROUP_TABLE_DEPTH > 1) ? $clog2(GROUP_TABLE_DEPTH) : 1;
    localparam int ADDR_W = 48;
    localparam int REFS_W = 32;
    localparam int CFG_DATA_W = 48;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_mac;
    typedef logic [3:0]        t_status;

    localparam t_idx LAST_IDX = IDX_W'(GROUP_TABLE_DEPTH - 1);

    localparam t_mac BCAST_ADDR = 48'hFFFF_FFFF_FFFF;
    localparam int   GROUP_BIT  = 40;
    localparam logic [15:0] HEADER_BYTES = 16'd14;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // Result status codes
    localparam t_status ST_SHORT    = 4'd0;
    localparam t_status ST_NOT_US   = 4'd1;
    localparam t_status ST_IPV4     = 4'd2;
    localparam t_status ST_ARP      = 4'd3;
    localparam t_status ST_IPV6     = 4'd4;
    localparam t_status ST_UNKNOWN  = 4'd5;
    localparam t_status ST_JOIN_NEW = 4'd6;
    localparam t_status ST_JOIN_OLD = 4'd7;
    localparam t_status ST_FULL     = 4'd8;

    // Request types
    localparam logic REQ_CLASSIFY = 1'b0;
    localparam logic REQ_JOIN     = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_PROMISCUOUS = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        req_type;
        t_mac        address;
        logic [15:0] ether_type;
        logic [15:0] frame_length;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] error_count;
    } t_out;

    // Table write command
    typedef struct packed {
        logic              en_addr;
        logic              en_refs;
        t_idx              idx;
        t_mac              addr;
        logic [REFS_W-1:0] refs;
    } t_tbl_wr;

    // Registered table read data
    typedef struct packed {
        logic              valid;
        t_mac              addr;
        logic [REFS_W-1:0] refs;
    } t_tbl_rd;

    function automatic t_status type_status(input logic [15:0] etype);
        t_status st;
        case (etype)
            TYPE_IPV4: st = ST_IPV4;
            TYPE_ARP:  st = ST_ARP;
            TYPE_IPV6: st = ST_IPV6;
            default:   st = ST_UNKNOWN;
        endcase
        return st;
    endfunction

endpackage

FILE: src/erxaf_group_table.sv
// ----------------------------------------------------------------------------
// erxaf_group_table
// Multicast group table: valid flops plus address and refcount memories.
// ----------------------------------------------------------------------------
module erxaf_group_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  erxaf_pkg::t_idx    i_rd_idx,
    output erxaf_pkg::t_tbl_rd o_rd,
    input  erxaf_pkg::t_tbl_wr i_wr
);

    logic [erxaf_pkg::GROUP_TABLE_DEPTH-1:0] r_valid;
    erxaf_pkg::t_mac mem_addr [erxaf_pkg::GROUP_TABLE_DEPTH];
    logic [erxaf_pkg::REFS_W-1:0] mem_refs [erxaf_pkg::GROUP_TABLE_DEPTH];

    erxaf_pkg::t_tbl_rd r_rd;

    // valid bits clear at reset; entries only get set, never freed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en_addr) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en_addr) begin
            mem_addr[i_wr.idx] <= i_wr.addr;
        end
        if (i_wr.en_refs) begin
            mem_refs[i_wr.idx] <= i_wr.refs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.valid <= r_valid[i_rd_idx];
        r_rd.addr  <= mem_addr[i_rd_idx];
        r_rd.refs  <= mem_refs[i_rd_idx];
    end

    assign o_rd = r_rd;

endmodule

FILE: src/ethernet_rx_address_filter.sv
// ----------------------------------------------------------------------------
// ethernet_rx_address_filter: receive address filter, one table entry compared per cycle
// A join or group lookup walks the table; other requests go straight to the hand-over state.
// One transaction at a time: a new request is stalled until the result has been handed over.
// Reset: synchronous active low; clears FSM, valid bits, counter and config.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ethernet_rx_address_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  erxaf_pkg::t_in                    i_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output erxaf_pkg::t_out                   o_out,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [erxaf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    erxaf_pkg::t_mac r_own;
    logic            r_promisc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own     <= '0;
            r_promisc <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                erxaf_pkg::CFG_OWN_ADDRESS: r_own     <= i_cfg_data;
                erxaf_pkg::CFG_PROMISCUOUS: r_promisc <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    erxaf_pkg::t_state  r_state, n_state;
    erxaf_pkg::t_in     r_req, n_req;        // latched transaction
    erxaf_pkg::t_idx    r_idx, n_idx;        // read address of the walk
    logic               r_issue_done, n_issue_done;
    logic               r_chk, n_chk;        // read data valid this cycle
    erxaf_pkg::t_idx    r_chk_idx, n_chk_idx;
    logic               r_free_found, n_free_found;
    erxaf_pkg::t_idx    r_free_idx, n_free_idx;
    erxaf_pkg::t_status r_status, n_status;
    logic [31:0]        r_err_cnt, n_err_cnt;
    logic               r_out_valid, n_out_valid;
    erxaf_pkg::t_out    r_out, n_out;

    erxaf_pkg::t_tbl_wr w_wr;
    erxaf_pkg::t_tbl_rd w_rd;
    logic               w_accept;
    logic               w_hit;
    logic               w_slot_free;

    erxaf_group_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd     (w_rd),
        .i_wr     (w_wr)
    );

    assign o_in_stall  = (r_state != erxaf_pkg::S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // the shared comparator: key against the entry read last cycle
    assign w_hit = r_chk && w_rd.valid && (w_rd.addr == r_req.address);

    // output register can take a new result this cycle
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_chk        = r_chk;
        n_chk_idx    = r_chk_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_status     = r_status;
        n_err_cnt    = r_err_cnt;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_wr         = '0;
        w_wr.idx     = r_chk_idx;
        w_wr.addr    = r_req.address;
        w_wr.refs    = '0;

        unique case (r_state)
            erxaf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_req        = i_in;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    n_chk        = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = erxaf_pkg::S_DONE;
                    if (i_in.req_type == erxaf_pkg::REQ_JOIN) begin
                        n_state = erxaf_pkg::S_SCAN;
                    end else if (i_in.frame_length < erxaf_pkg::HEADER_BYTES) begin
                        n_status = erxaf_pkg::ST_SHORT;
                    end else if (i_in.address == erxaf_pkg::BCAST_ADDR ||
                                 i_in.address == r_own || r_promisc) begin
                        n_status = erxaf_pkg::type_status(i_in.ether_type);
                    end else if (!i_in.address[erxaf_pkg::GROUP_BIT]) begin
                        n_status = erxaf_pkg::ST_NOT_US;
                    end else begin
                        n_state = erxaf_pkg::S_SCAN;
                    end
                end
            end

            erxaf_pkg::S_SCAN: begin
                // issue side: one read per cycle until the last entry
                n_chk     = !r_issue_done;
                n_chk_idx = r_idx;
                if (!r_issue_done) begin
                    if (r_idx == erxaf_pkg::LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end

                // check side
                if (r_chk) begin
                    if (!w_rd.valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_idx;
                    end
                    if (w_hit) begin
                        n_state = erxaf_pkg::S_DONE;
                        if (r_req.req_type == erxaf_pkg::REQ_JOIN) begin
                            w_wr.en_refs = 1'b1;
                            w_wr.refs    = (w_rd.refs == erxaf_pkg::REFS_MAX) ?
                                           w_rd.refs : w_rd.refs + 1'b1;
                            n_status     = erxaf_pkg::ST_JOIN_OLD;
                        end else begin
                            n_status = erxaf_pkg::type_status(r_req.ether_type);
                        end
                    end else if (r_chk_idx == erxaf_pkg::LAST_IDX) begin
                        n_state = erxaf_pkg::S_DONE;
                        if (r_req.req_type == erxaf_pkg::REQ_JOIN) begin
                            if (r_free_found || !w_rd.valid) begin
                                // lowest free entry takes the new group
                                w_wr.en_addr = 1'b1;
                                w_wr.en_refs = 1'b1;
                                w_wr.idx     = r_free_found ? r_free_idx : r_chk_idx;
                                w_wr.refs    = erxaf_pkg::REFS_W'(1);
                                n_status     = erxaf_pkg::ST_JOIN_NEW;
                            end else begin
                                n_status = erxaf_pkg::ST_FULL;
                            end
                        end else begin
                            n_status = erxaf_pkg::ST_NOT_US;
                        end
                    end
                end
            end

            erxaf_pkg::S_DONE: begin
                // hand the result over once the output register frees up;
                // the error counter moves with the result that bumps it
                if (w_slot_free) begin
                    if (r_status == erxaf_pkg::ST_UNKNOWN) begin
                        n_err_cnt = r_err_cnt + 32'd1;
                    end
                    n_out.status      = r_status;
                    n_out.error_count = n_err_cnt;
                    n_out_valid       = 1'b1;
                    n_state           = erxaf_pkg::S_IDLE;
                end
            end

            default: n_state = erxaf_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= erxaf_pkg::S_IDLE;
            r_issue_done <= 1'b0;
            r_chk        <= 1'b0;
            r_free_found <= 1'b0;
            r_err_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_chk        <= n_chk;
            r_free_found <= n_free_found;
            r_err_cnt    <= n_err_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a new result only ever comes from the hand-over state
    `ASSERT_CLK(a_out_from_done, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state) == erxaf_pkg::S_DONE,
        "result raised outside hand-over")

    // the group table is only written during a walk
    `ASSERT_CLK(a_wr_in_scan, i_clk, i_rst_n,
        (w_wr.en_addr || w_wr.en_refs) |-> r_state == erxaf_pkg::S_SCAN,
        "table write outside walk")

    // the error counter steps only with an unknown-type result
    `ASSERT_CLK(a_err_step, i_clk, i_rst_n,
        ($past(i_rst_n) && !$stable(r_err_cnt)) |->
            (o_out.status == erxaf_pkg::ST_UNKNOWN && o_out.error_count == r_err_cnt),
        "error counter moved without unknown type")

    // a new entry is never written while a hit was found
    `ASSERT_NEVER(a_new_on_hit, i_clk, i_rst_n,
        w_wr.en_addr && w_hit,
        "new group written on a table hit")

endmodule
